>>> rtl/core/cira_pkg.sv
// cira_pkg: types and constants for the cpu idle ratio averager
// payload structs, state encoding, status codes and datapath widths
// no dependencies
package cira_pkg;

  localparam int CTR_W       = 32;   // counter width of one snapshot field
  localparam int CTR_N       = 8;    // counters per snapshot
  localparam int IDLE_SLOT   = 3;    // position of the idle counter
  localparam int TOT_W       = 35;   // sum of eight deltas never wraps
  localparam int A_W         = 41;   // 100*idle + total/2
  localparam int NUM_W       = 48;   // 100*(100*idle + total/2)
  localparam int Q_W         = 14;   // quotient bits, results stay below 2^14
  localparam int REM_W       = TOT_W;
  localparam int CNT_W       = 5;
  localparam int STAT_W      = 2;
  localparam int SAMPLE_MAX  = 10050;
  localparam int WINDOW_DEPTH_DEF = 30;

  localparam logic [Q_W-1:0]   FULL_SCALE = Q_W'(10000);
  localparam logic [CNT_W-1:0] SHIFT_LAST = CNT_W'(CTR_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(Q_W - 1);

  localparam logic [STAT_W-1:0] STAT_PRIMED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SAMPLE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SKIP   = 2'd2;

  typedef struct packed {
    logic [CTR_W-1:0] user_count;
    logic [CTR_W-1:0] nice_count;
    logic [CTR_W-1:0] system_count;
    logic [CTR_W-1:0] idle_count;
    logic [CTR_W-1:0] iowait_count;
    logic [CTR_W-1:0] irq_count;
    logic [CTR_W-1:0] softirq_count;
    logic [CTR_W-1:0] steal_count;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [Q_W-1:0]    idle_average;
    logic [Q_W-1:0]    latest_sample;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_CHECK,
    ST_MUL1,
    ST_MUL2,
    ST_SDIV,
    ST_UPDATE,
    ST_ADIV,
    ST_SAT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/cpu_idle_ratio_averager.sv
// cpu_idle_ratio_averager: moving average of the cpu idle share from counter snapshots
// bit-serial delta engine, radix-2 divider shared by sample and average
// depends on cira_pkg
//
//   channel | signals                    | direction | transfer when
//   --------+----------------------------+-----------+-----------------------
//   in      | in_valid in_ready in_data  | input     | in_valid & in_ready
//   out     | out_valid out_ready out_data| output   | out_valid & out_ready
//   cfg     | cfg_valid cfg_ready cfg_data| input    | cfg_valid & cfg_ready
//
// after the input transfer the bit-serial delta subtractors work through every bit of the
// counters; a snapshot that primes the baselines or has a zero total then goes straight to
// the result, and a sample first takes two passes of the one-bit-per-cycle divider (sample,
// then average); with a free output the next snapshot can transfer in the cycle after the
// result is loaded
// in_ready is high only while idle; a result waiting in the output register
// does not block the next snapshot, only the final load of the next result
// rst_n is synchronous and active low; cfg is always ready
module cpu_idle_ratio_averager
  import cira_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  // width of the fill index (must hold the depth itself) and the running sum
  localparam int IDX_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = $clog2(WINDOW_DEPTH * SAMPLE_MAX + 1);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(WINDOW_DEPTH);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;

  // snapshot and baseline shift registers, lsb first
  logic [CTR_W-1:0] snap_r [CTR_N];
  logic [CTR_W-1:0] base_r [CTR_N];
  logic [CTR_N-1:0] borrow_r;
  logic [CTR_N-1:0] borrow_nxt;
  logic [CTR_N-1:0] dbit;

  // serial column adder for the total
  logic [CTR_W-1:0]   tot_r;
  logic [2:0]         carry_r;
  logic [3:0]         col_sum;
  logic [CTR_W-1:0]   idle_r;
  logic [TOT_W-1:0]   total_w;

  logic [A_W-1:0]     a_r;
  logic [NUM_W-1:0]   num_w;

  // divider
  logic [REM_W-1:0]   rem_r;
  logic [Q_W-1:0]     lo_r;
  logic [TOT_W-1:0]   den_r;
  logic [REM_W:0]     trial;
  logic               ge;

  logic               primed_r;
  logic [IDX_W-1:0]   idx_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [Q_W-1:0]     avg_r;
  logic [Q_W-1:0]     sample_r;
  logic [STAT_W-1:0]  status_r;
  logic               enable_r;

  logic               out_valid_r;
  out_item_t          out_r;
  logic               out_load;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // one bit of each delta per cycle, with its own borrow
  always_comb begin
    for (int k = 0; k < CTR_N; k++) begin
      dbit[k]       = snap_r[k][0] ^ base_r[k][0] ^ borrow_r[k];
      borrow_nxt[k] = (~snap_r[k][0] & base_r[k][0]) |
                      (~(snap_r[k][0] ^ base_r[k][0]) & borrow_r[k]);
    end
  end

  // column of eight delta bits plus the carry from the previous column
  always_comb begin
    col_sum = {1'b0, carry_r};
    for (int k = 0; k < CTR_N; k++) begin
      col_sum = col_sum + {3'b000, dbit[k]};
    end
  end

  assign total_w = {carry_r, tot_r};

  // times 100 as three shifted terms
  assign num_w = (NUM_W'(a_r) << 6) + (NUM_W'(a_r) << 5) + (NUM_W'(a_r) << 2);

  // restoring divide step: quotient bits enter lo_r from the bottom
  assign trial = {rem_r, lo_r[Q_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // slot 0 restarts the window, otherwise the new sample adds to the window sum
  assign sum_nxt = ((idx_r == '0) ? '0 : sum_r) + SUM_W'(lo_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (cnt_r == SHIFT_LAST) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!primed_r || total_w == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SDIV;
      ST_SDIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_ADIV;
      ST_ADIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs of the controller
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable_r <= cfg_data;
    end
  end

  // baselines: snapshot bits slide in from the top as old bits leave
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CTR_N; k++) begin
        base_r[k] <= '0;
      end
    end else if (state_r == ST_SHIFT) begin
      for (int k = 0; k < CTR_N; k++) begin
        base_r[k] <= {snap_r[k][0], base_r[k][CTR_W-1:1]};
      end
    end
  end

  // snapshot capture and delta shifting
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      snap_r[0] <= in_data.user_count;
      snap_r[1] <= in_data.nice_count;
      snap_r[2] <= in_data.system_count;
      snap_r[3] <= in_data.idle_count;
      snap_r[4] <= in_data.iowait_count;
      snap_r[5] <= in_data.irq_count;
      snap_r[6] <= in_data.softirq_count;
      snap_r[7] <= in_data.steal_count;
      borrow_r  <= '0;
      carry_r   <= '0;
    end else if (state_r == ST_SHIFT) begin
      for (int k = 0; k < CTR_N; k++) begin
        snap_r[k] <= snap_r[k] >> 1;
      end
      borrow_r <= borrow_nxt;
      carry_r  <= col_sum[3:1];
      tot_r    <= {col_sum[0], tot_r[CTR_W-1:1]};
      idle_r   <= {dbit[IDLE_SLOT], idle_r[CTR_W-1:1]};
    end
  end

  // step counter for the shift and divide phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (state_r == ST_SHIFT || state_r == ST_SDIV || state_r == ST_ADIV) begin
      cnt_r <= (cnt_r == SHIFT_LAST || (cnt_r == DIV_LAST && state_r != ST_SHIFT)) ?
               '0 : cnt_r + 1'b1;
    end else begin
      cnt_r <= '0;
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_CHECK: begin
        sample_r <= '0;
        if (!primed_r) begin
          status_r <= STAT_PRIMED;
        end else begin
          status_r <= (total_w == '0) ? STAT_SKIP : STAT_SAMPLE;
        end
      end
      ST_MUL1: begin
        a_r <= (A_W'(idle_r) << 6) + (A_W'(idle_r) << 5) + (A_W'(idle_r) << 2) +
               A_W'(total_w[TOT_W-1:1]);
      end
      ST_MUL2: begin
        rem_r <= REM_W'(num_w[NUM_W-1:Q_W]);
        lo_r  <= num_w[Q_W-1:0];
        den_r <= total_w;
      end
      ST_SDIV, ST_ADIV: begin
        rem_r <= ge ? REM_W'(trial - {1'b0, den_r}) : REM_W'(trial);
        lo_r  <= {lo_r[Q_W-2:0], ge};
      end
      ST_UPDATE: begin
        sample_r <= lo_r;
        rem_r    <= REM_W'(sum_nxt >> Q_W);
        lo_r     <= sum_nxt[Q_W-1:0];
        den_r    <= TOT_W'(idx_r + 1'b1);
      end
      default: begin
      end
    endcase
  end

  // window state: primed flag, fill index, running sum, stored average
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      idx_r    <= IDX_W'(1);
      sum_r    <= SUM_W'(FULL_SCALE);
      avg_r    <= '0;
    end else begin
      case (state_r)
        ST_CHECK: begin
          primed_r <= 1'b1;
          // index restart happens on a primed snapshot once the index has reached the depth, before the zero test
          if (primed_r && idx_r >= DEPTH_IDX) begin
            idx_r <= '0;
          end
        end
        ST_UPDATE: begin
          sum_r <= sum_nxt;
          idx_r <= idx_r + 1'b1;
        end
        ST_SAT: begin
          avg_r <= (lo_r > FULL_SCALE) ? FULL_SCALE : lo_r;
        end
        default: begin
        end
      endcase
    end
  end

  // output register, frees the controller as soon as the result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.status        <= status_r;
      out_r.idle_average  <= enable_r ? avg_r : FULL_SCALE;
      out_r.latest_sample <= sample_r;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SHIFT))
    else $error("snapshot transfer did not start the shift phase");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SDIV || state_r == ST_ADIV) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= DEPTH_IDX)
    else $error("fill index beyond window depth");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result offered outside the done state");

  a_avg_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    avg_r <= FULL_SCALE)
    else $error("stored average above full scale");
`endif

endmodule

>>> sim/cira_checker.sv
// cira_checker: watches the snapshot, result and enable channels of the averager,
// predicts each result and compares it with what the block returns
// depends on cira_pkg
`timescale 1ns / 100ps
module cira_checker
  import cira_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  output int        err_count,
  output int        pending
);

  // predicted block state
  logic [CTR_W-1:0] base_ctr [CTR_N];
  logic             primed;
  logic [Q_W-1:0]   share_ring [WINDOW_DEPTH];
  int unsigned      fill_idx;
  logic [Q_W-1:0]   avg_stored;
  logic             mon_en;

  out_item_t awaited_results [$];
  int mismatches = 0;
  int backlog = 0;

  assign err_count = mismatches;
  assign pending   = backlog;

  task automatic reset_idle_share();
    for (int k = 0; k < CTR_N; k++) base_ctr[k] = '0;
    for (int k = 0; k < WINDOW_DEPTH; k++) share_ring[k] = '0;
    share_ring[0] = FULL_SCALE;
    primed     = 1'b0;
    fill_idx   = 1;
    avg_stored = '0;
    mon_en     = 1'b1;
  endtask

  task automatic advance_idle_share(input in_item_t snap, output out_item_t res);
    logic [CTR_W-1:0] now [CTR_N];
    logic [CTR_W-1:0] delta;
    logic [CTR_W-1:0] idle_d;
    logic [TOT_W-1:0] total;
    logic [63:0]      numer;
    logic [63:0]      share;
    logic [63:0]      acc;
    now = '{snap.user_count, snap.nice_count, snap.system_count, snap.idle_count,
            snap.iowait_count, snap.irq_count, snap.softirq_count, snap.steal_count};
    total  = '0;
    idle_d = '0;
    for (int k = 0; k < CTR_N; k++) begin
      delta = now[k] - base_ctr[k];
      total = total + TOT_W'(delta);
      if (k == IDLE_SLOT) idle_d = delta;
      base_ctr[k] = now[k];
    end
    res.latest_sample = '0;
    if (!primed) begin
      primed     = 1'b1;
      res.status = STAT_PRIMED;
    end else begin
      if (fill_idx >= WINDOW_DEPTH) fill_idx = 0;
      if (total == '0) begin
        res.status = STAT_SKIP;
      end else begin
        numer = 64'd100 * (64'd100 * idle_d + total / 2);
        share = numer / total;
        share_ring[fill_idx] = Q_W'(share);
        fill_idx++;
        acc = '0;
        for (int k = 0; k < fill_idx; k++) acc = acc + share_ring[k];
        acc = acc / fill_idx;
        if (acc > FULL_SCALE) acc = FULL_SCALE;
        avg_stored        = Q_W'(acc);
        res.status        = STAT_SAMPLE;
        res.latest_sample = Q_W'(share);
      end
    end
    res.idle_average = mon_en ? avg_stored : FULL_SCALE;
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      reset_idle_share();
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) mon_en = cfg_data;
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result status %0d average %0d sample %0d", $time,
                   out_data.status, out_data.idle_average, out_data.latest_sample);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("idle_average", want.idle_average, out_data.idle_average);
          check_field("latest_sample", want.latest_sample, out_data.latest_sample);
        end
      end
      if (in_valid && in_ready) begin
        advance_idle_share(in_data, fresh);
        awaited_results.push_back(fresh);
      end
    end
    backlog <= awaited_results.size();
  end

endmodule

>>> sim/tb_cpu_idle_ratio_averager.sv
// tb_cpu_idle_ratio_averager: stimulus and verdict for the cpu idle ratio averager
// drives counter snapshots and enable writes; prediction lives in cira_checker
// depends on cira_pkg, cira_checker and the block itself
`timescale 1ns / 100ps
module tb_cpu_idle_ratio_averager
  import cira_pkg::*;
();

  localparam int LIMIT_CYCLES = 1_000_000; // far above the slowest legal run
  localparam int RANDOM_ITEMS = 600;
  localparam int PHASE_ITEMS  = 150;       // enable flips between phases
  localparam int DRAIN_CYCLES = 100;       // above the sample latency

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  int err_count;
  int pending;
  int cycles     = 0;
  int stall_left = 0;
  bit quiet      = 1'b0;   // when set neither side inserts idle cycles

  always #5 clk = ~clk;

  cpu_idle_ratio_averager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  cira_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // idle length: mostly a few cycles, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // result side stalls on its own schedule, independent of out_valid
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  // counter advance per field: often nothing or a little, sometimes a full-range jump
  function automatic logic [CTR_W-1:0] pick_delta();
    case ($urandom_range(0, 9))
      0, 1:       return '0;
      2, 3, 4, 5: return CTR_W'($urandom_range(0, 1000));
      6, 7:       return CTR_W'($urandom_range(0, 1 << 20));
      8:          return CTR_W'($urandom);
      default:    return CTR_W'($urandom_range(0, 4));
    endcase
  endfunction

  function automatic in_item_t splat(input logic [CTR_W-1:0] v);
    return {CTR_N{v}};
  endfunction

  // offer one snapshot; valid stays high afterwards unless a gap lowers it
  task automatic send_snapshot(input in_item_t snap);
    int gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = gap_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= snap;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_enable(input logic en);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_item_t snap;
    int       mode;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, monitor enabled from reset
    snap = splat('0);
    send_snapshot(snap);                 // priming only
    send_snapshot(snap);                 // nothing moved, zero total
    snap.idle_count += 2;
    send_snapshot(snap);                 // idle 2 of 2 gives the top sample, average clamps
    snap.user_count += 1;
    send_snapshot(snap);                 // no idle time at all
    snap.idle_count += 1;
    send_snapshot(snap);                 // one tick, all idle
    snap = splat('1);
    send_snapshot(snap);                 // near-full deltas on every counter
    snap = splat('0);
    send_snapshot(snap);                 // every counter wraps past zero
    snap = splat(32'h8000_0000);
    send_snapshot(snap);
    snap = splat(32'h7fff_ffff);
    send_snapshot(snap);                 // every counter steps back by one
    snap.idle_count -= 1;
    send_snapshot(snap);                 // idle delta all ones, rest zero
    snap = splat(32'h7fff_fffe);
    snap.idle_count = 32'h7fff_fffe;
    send_snapshot(snap);                 // others all ones, idle zero
    snap = splat(32'haaaa_aaaa);
    send_snapshot(snap);
    snap = splat(32'h5555_5555);
    send_snapshot(snap);
    snap.steal_count  += 32'd7;
    snap.idle_count   += 32'd3;
    snap.irq_count    += 32'd5;
    send_snapshot(snap);

    // random part in phases; enable alternates off, on, off, on
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        wait_drained();
        write_enable((n / PHASE_ITEMS) % 2 == 1);
      end
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
        // noise: unrelated absolute values, deltas wrap freely
        snap = {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
      end else if (mode > 2) begin
        snap.user_count    += pick_delta();
        snap.nice_count    += pick_delta();
        snap.system_count  += pick_delta();
        snap.idle_count    += pick_delta();
        snap.iowait_count  += pick_delta();
        snap.irq_count     += pick_delta();
        snap.softirq_count += pick_delta();
        snap.steal_count   += pick_delta();
      end
      // modes 1 and 2 repeat the snapshot for a zero total
      send_snapshot(snap);
    end

    wait_drained();
    quiet = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> cpu_idle_ratio_averager.f
rtl/core/cira_pkg.sv
rtl/core/cpu_idle_ratio_averager.sv
sim/cira_checker.sv
sim/tb_cpu_idle_ratio_averager.sv
